>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge outside reset
`define VPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define VPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/vpp_pkg.sv
// ----------------------------------------------------------------------------
// vpp_pkg
// action codes, register indexes and the control bundle of the divider chain
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] ACT_PROJ  = 2'd0;
    localparam logic [1:0] ACT_PERSP = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_IS_3D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_Z         = 3'd5;

    typedef struct packed {
        logic       eol;
        logic       apply;
        logic       zero_z;
        logic [2:0] psat;
        logic [2:0] ovf;
        logic [2:0] neg;
    } ctl_t;

endpackage

>>> sv/view_projection_perspective.sv
// ----------------------------------------------------------------------------
// view_projection_perspective
// 3d view rotation and perspective divide for one vertex per beat
// ----------------------------------------------------------------------------
// Takes one vertex beat per clock while in_ready is high and returns one
// result beat per vertex, in order. The path runs through the matrix
// projection, the perspective setup and product, a chain of COORD_WIDTH divider
// cells that each give one quotient bit, and one output register. Throughput is
// one vertex per cycle while out_ready is high; a stalled output holds full stages.
`include "assert_macros.svh"

module view_projection_perspective #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]          cfg_addr,
    input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             action,
    input  logic signed [COORD_WIDTH-1:0]          x_in,
    input  logic signed [COORD_WIDTH-1:0]          y_in,
    input  logic signed [COORD_WIDTH-1:0]          z_in,
    input  logic                                   end_of_line,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [COORD_WIDTH-1:0]          x_out,
    output logic signed [COORD_WIDTH-1:0]          y_out,
    output logic signed [COORD_WIDTH-1:0]          z_out,
    output logic                                   perspective_applied,
    output logic                                   saturated,
    output logic                                   end_of_line_out
);

    localparam int CW    = COORD_WIDTH;
    localparam int KW    = COEF_WIDTH;
    localparam int DEPTH = CW + 5;
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic [KW-1:0]   ONE   = KW'(1) << (KW - 2);
    localparam logic [KW-1:0]   ZERO  = '0;
    localparam logic [3*KW-1:0] R1_RST = {ONE, ZERO, ZERO};
    localparam logic [3*KW-1:0] R2_RST = {ZERO, ONE, ZERO};
    localparam logic [3*KW-1:0] R3_RST = {ZERO, ZERO, ONE};

    logic [3*KW-1:0]      row_one_reg;
    logic [3*KW-1:0]      row_two_reg;
    logic [3*KW-1:0]      row_three_reg;
    logic                 view_is_3d_reg;
    logic [CW-1:0]        view_distance_reg;
    logic                 gen_z_reg;

    logic                 p_valid;
    logic                 p_ready;
    logic [1:0]           p_action;
    logic [2:0][CW-1:0]   p_c;
    logic                 p_eol;
    logic [2:0]           p_sat;

    logic                 c_valid [0:CW];
    logic                 c_ready [0:CW];
    vpp_pkg::ctl_t        c_ctl [0:CW];
    logic [CW-1:0]        c_den [0:CW];
    logic [2:0][CW-1:0]   c_rem [0:CW];
    logic [2:0][CW-1:0]   c_sh [0:CW];
    logic [2:0][CW-1:0]   c_byp [0:CW];

    logic                 out_valid_reg;
    logic [2:0][CW-1:0]   res_next;
    logic [2:0]           flag_next;
    logic [2:0][CW-1:0]   res_reg;
    logic                 applied_reg;
    logic                 sat_reg;
    logic                 eol_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_one_reg       <= R1_RST;
            row_two_reg       <= R2_RST;
            row_three_reg     <= R3_RST;
            view_is_3d_reg    <= 1'b0;
            view_distance_reg <= '0;
            gen_z_reg         <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                vpp_pkg::REG_ROW_ONE:       row_one_reg       <= cfg_wdata[3*KW-1:0];
                vpp_pkg::REG_ROW_TWO:       row_two_reg       <= cfg_wdata[3*KW-1:0];
                vpp_pkg::REG_ROW_THREE:     row_three_reg     <= cfg_wdata[3*KW-1:0];
                vpp_pkg::REG_VIEW_IS_3D:    view_is_3d_reg    <= cfg_wdata[0];
                vpp_pkg::REG_VIEW_DISTANCE: view_distance_reg <= cfg_wdata[CW-1:0];
                vpp_pkg::REG_GEN_Z:         gen_z_reg         <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    vpp_proj #(
        .CW (CW),
        .KW (KW)
    ) u_proj (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .x_in       (x_in),
        .y_in       (y_in),
        .z_in       (z_in),
        .eol        (end_of_line),
        .row_one    (row_one_reg),
        .row_two    (row_two_reg),
        .row_three  (row_three_reg),
        .view_is_3d (view_is_3d_reg),
        .out_valid  (p_valid),
        .out_ready  (p_ready),
        .out_action (p_action),
        .out_c      (p_c),
        .out_eol    (p_eol),
        .out_sat    (p_sat)
    );

    vpp_scale #(
        .CW (CW)
    ) u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (p_valid),
        .in_ready      (p_ready),
        .action        (p_action),
        .c_in          (p_c),
        .eol           (p_eol),
        .sat_in        (p_sat),
        .view_distance (view_distance_reg),
        .gen_z         (gen_z_reg),
        .out_valid     (c_valid[0]),
        .out_ready     (c_ready[0]),
        .out_ctl       (c_ctl[0]),
        .out_den       (c_den[0]),
        .out_rem       (c_rem[0]),
        .out_sh        (c_sh[0]),
        .out_byp       (c_byp[0])
    );

    for (genvar k = 0; k < CW; k++)
    begin : g_cell
        vpp_div_cell #(
            .CW (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_ctl    (c_ctl[k]),
            .in_den    (c_den[k]),
            .in_rem    (c_rem[k]),
            .in_sh     (c_sh[k]),
            .in_byp    (c_byp[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_ctl   (c_ctl[k+1]),
            .out_den   (c_den[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_sh    (c_sh[k+1]),
            .out_byp   (c_byp[k+1])
        );
    end

    assign c_ready[CW] = !out_valid_reg || out_ready;

    // saturate quotient, restore sign, pick bypass when no perspective, clear z on zero_z
    always_comb
    begin
        logic [CW-1:0] q;
        logic [CW-1:0] limit;
        logic [CW-1:0] qs;
        logic          of;
        for (int l = 0; l < 3; l++)
        begin
            q     = c_sh[CW][l];
            limit = c_ctl[CW].neg[l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            of    = c_ctl[CW].ovf[l] || (q > limit);
            qs    = of ? limit : q;
            if (c_ctl[CW].apply)
            begin
                res_next[l]  = c_ctl[CW].neg[l] ? (~qs + CW'(1)) : qs;
                flag_next[l] = c_ctl[CW].psat[l] || of;
            end
            else
            begin
                res_next[l]  = c_byp[CW][l];
                flag_next[l] = c_ctl[CW].psat[l];
            end
        end
        if (c_ctl[CW].zero_z)
        begin
            res_next[2]  = '0;
            flag_next[2] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (c_ready[CW])
            begin
                out_valid_reg <= c_valid[CW];
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_valid[CW] && c_ready[CW])
        begin
            res_reg     <= res_next;
            applied_reg <= c_ctl[CW].apply;
            sat_reg     <= |flag_next;
            eol_reg     <= c_ctl[CW].eol;
        end
    end

    assign occ_next = occ_reg + OCC_W'(in_valid && in_ready) - OCC_W'(out_valid && out_ready);

    assign out_valid           = out_valid_reg;
    assign x_out               = res_reg[0];
    assign y_out               = res_reg[1];
    assign z_out               = res_reg[2];
    assign perspective_applied = applied_reg;
    assign saturated           = sat_reg;
    assign end_of_line_out     = eol_reg;

    `VPP_ASSERT(a_occ_bound, occ_reg <= OCC_W'(DEPTH), "more vertices in flight than stages")
    `VPP_ASSERT_IMP(a_no_phantom, out_valid, occ_reg != '0, "result beat with no vertex in flight")

endmodule

>>> sv/vpp_proj.sv
// ----------------------------------------------------------------------------
// vpp_proj
// matrix projection: products in the first stage, row sums and clamp in the second
// ----------------------------------------------------------------------------
module vpp_proj #(
    parameter int CW = 32,
    parameter int KW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    input  logic                 eol,
    input  logic [3*KW-1:0]      row_one,
    input  logic [3*KW-1:0]      row_two,
    input  logic [3*KW-1:0]      row_three,
    input  logic                 view_is_3d,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_action,
    output logic [2:0][CW-1:0]   out_c,
    output logic                 out_eol,
    output logic [2:0]           out_sat
);

    localparam int PW   = KW + CW;
    localparam int SW   = PW + 2;
    localparam int FRAC = KW - 2;

    logic [3*KW-1:0]      rows [0:2];
    logic signed [CW-1:0] cin [0:2];
    logic signed [PW-1:0] prod_next [0:2][0:2];
    logic signed [PW-1:0] prod_reg [0:2][0:2];
    logic signed [CW-1:0] c_reg [0:2];
    logic [1:0]           action_reg;
    logic                 eol_reg;
    logic                 proj_reg;
    logic                 va_reg;
    logic                 vb_reg;
    logic                 rdy_a;
    logic                 rdy_b;
    logic [2:0][CW-1:0]   c_next;
    logic [2:0]           sat_next;
    logic [2:0][CW-1:0]   c_out_reg;
    logic [2:0]           sat_reg;
    logic [1:0]           action_out_reg;
    logic                 eol_out_reg;

    assign rows[0] = row_one;
    assign rows[1] = row_two;
    assign rows[2] = row_three;
    assign cin[0]  = x_in;
    assign cin[1]  = y_in;
    assign cin[2]  = z_in;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_next[r][i] = PW'($signed(rows[r][(2-i)*KW +: KW])) * PW'(cin[i]);
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] sh;
        logic                 of;
        for (int r = 0; r < 3; r++)
        begin
            sum = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2]);
            sh  = sum >>> FRAC;
            of  = (sh[SW-1:CW-1] != '0) && (sh[SW-1:CW-1] != '1);
            if (!proj_reg)
            begin
                c_next[r]   = c_reg[r];
                sat_next[r] = 1'b0;
            end
            else if (of)
            begin
                c_next[r]   = sh[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
                sat_next[r] = 1'b1;
            end
            else
            begin
                c_next[r]   = sh[CW-1:0];
                sat_next[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy_a)
        begin
            prod_reg   <= prod_next;
            c_reg      <= cin;
            action_reg <= action;
            eol_reg    <= eol;
            proj_reg   <= (action != vpp_pkg::ACT_PERSP) && view_is_3d;
        end
        if (va_reg && rdy_b)
        begin
            c_out_reg      <= c_next;
            sat_reg        <= sat_next;
            action_out_reg <= action_reg;
            eol_out_reg    <= eol_reg;
        end
    end

    assign out_valid  = vb_reg;
    assign out_c      = c_out_reg;
    assign out_sat    = sat_reg;
    assign out_action = action_out_reg;
    assign out_eol    = eol_out_reg;

endmodule

>>> sv/vpp_scale.sv
// ----------------------------------------------------------------------------
// vpp_scale
// perspective setup: depth test, split product with the distance, divider seed
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpp_scale #(
    parameter int CW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [2:0][CW-1:0]  c_in,
    input  logic                eol,
    input  logic [2:0]          sat_in,
    input  logic [CW-1:0]       view_distance,
    input  logic                gen_z,
    output logic                out_valid,
    input  logic                out_ready,
    output vpp_pkg::ctl_t       out_ctl,
    output logic [CW-1:0]       out_den,
    output logic [2:0][CW-1:0]  out_rem,
    output logic [2:0][CW-1:0]  out_sh,
    output logic [2:0][CW-1:0]  out_byp
);

    localparam int H  = (CW + 1) / 2;
    localparam int DW = 2 * CW;

    logic [CW:0]          dz;
    logic [CW-1:0]        ad;
    logic                 dz_pos;
    vpp_pkg::ctl_t        ctl_next;
    logic [CW+H-1:0]      plo_next [0:2];
    logic [DW-H-1:0]      phi_next [0:2];
    logic [CW+H-1:0]      plo_reg [0:2];
    logic [DW-H-1:0]      phi_reg [0:2];
    vpp_pkg::ctl_t        ctl_a_reg;
    logic [CW-1:0]        den_a_reg;
    logic [2:0][CW-1:0]   byp_a_reg;
    logic                 va_reg;
    logic                 vb_reg;
    logic                 rdy_a;
    logic                 rdy_b;
    logic [2:0]           ovf_b;
    logic [2:0][CW-1:0]   rem_b;
    logic [2:0][CW-1:0]   sh_b;
    vpp_pkg::ctl_t        ctl_b_next;
    vpp_pkg::ctl_t        ctl_b_reg;
    logic [CW-1:0]        den_b_reg;
    logic [2:0][CW-1:0]   rem_b_reg;
    logic [2:0][CW-1:0]   sh_b_reg;
    logic [2:0][CW-1:0]   byp_b_reg;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        logic [CW-1:0] ac;
        dz     = {view_distance[CW-1], view_distance} - {c_in[2][CW-1], c_in[2]};
        dz_pos = !dz[CW] && (dz != '0);
        ad     = view_distance[CW-1] ? (~view_distance + CW'(1)) : view_distance;
        ctl_next.eol    = eol;
        ctl_next.apply  = (action != vpp_pkg::ACT_PROJ)
                          && ((action == vpp_pkg::ACT_PERSP) || (view_distance != '0))
                          && dz_pos;
        ctl_next.zero_z = (action == vpp_pkg::ACT_PROJ) ? !gen_z
                                                         : (action != vpp_pkg::ACT_PERSP);
        ctl_next.psat   = sat_in;
        ctl_next.ovf    = '0;
        for (int l = 0; l < 3; l++)
        begin
            ac              = c_in[l][CW-1] ? (~c_in[l] + CW'(1)) : c_in[l];
            ctl_next.neg[l] = c_in[l][CW-1] ^ view_distance[CW-1];
            plo_next[l]     = (CW+H)'(ac) * (CW+H)'(ad[H-1:0]);
            phi_next[l]     = (DW-H)'(ac) * (DW-H)'(ad[CW-1:H]);
        end
    end

    always_comb
    begin
        logic [DW-1:0] prod;
        ctl_b_next = ctl_a_reg;
        for (int l = 0; l < 3; l++)
        begin
            prod     = DW'(plo_reg[l]) + (DW'(phi_reg[l]) << H);
            ovf_b[l] = prod[DW-1:CW] >= den_a_reg;
            rem_b[l] = prod[DW-1:CW];
            sh_b[l]  = prod[CW-1:0];
        end
        ctl_b_next.ovf = ovf_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy_a)
        begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            ctl_a_reg <= ctl_next;
            den_a_reg <= dz[CW-1:0];
            byp_a_reg <= c_in;
        end
        if (va_reg && rdy_b)
        begin
            ctl_b_reg <= ctl_b_next;
            den_b_reg <= den_a_reg;
            rem_b_reg <= rem_b;
            sh_b_reg  <= sh_b;
            byp_b_reg <= byp_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_ctl   = ctl_b_reg;
    assign out_den   = den_b_reg;
    assign out_rem   = rem_b_reg;
    assign out_sh    = sh_b_reg;
    assign out_byp   = byp_b_reg;

    `VPP_ASSERT_IMP(a_den_nonzero, vb_reg && ctl_b_reg.apply, den_b_reg != '0, "zero divisor")

endmodule

>>> sv/vpp_div_cell.sv
// ----------------------------------------------------------------------------
// vpp_div_cell
// one restoring division step for the three coordinate lanes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpp_div_cell #(
    parameter int CW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vpp_pkg::ctl_t       in_ctl,
    input  logic [CW-1:0]       in_den,
    input  logic [2:0][CW-1:0]  in_rem,
    input  logic [2:0][CW-1:0]  in_sh,
    input  logic [2:0][CW-1:0]  in_byp,
    output logic                out_valid,
    input  logic                out_ready,
    output vpp_pkg::ctl_t       out_ctl,
    output logic [CW-1:0]       out_den,
    output logic [2:0][CW-1:0]  out_rem,
    output logic [2:0][CW-1:0]  out_sh,
    output logic [2:0][CW-1:0]  out_byp
);

    logic                v_reg;
    vpp_pkg::ctl_t       ctl_reg;
    logic [CW-1:0]       den_reg;
    logic [2:0][CW-1:0]  rem_reg;
    logic [2:0][CW-1:0]  sh_reg;
    logic [2:0][CW-1:0]  byp_reg;
    logic [2:0][CW-1:0]  rem_next;
    logic [2:0][CW-1:0]  sh_next;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        logic [CW:0] t;
        logic [CW:0] diff;
        logic        ge;
        for (int l = 0; l < 3; l++)
        begin
            t           = {in_rem[l], in_sh[l][CW-1]};
            diff        = t - {1'b0, in_den};
            ge          = t >= {1'b0, in_den};
            rem_next[l] = ge ? diff[CW-1:0] : t[CW-1:0];
            sh_next[l]  = {in_sh[l][CW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctl_reg <= in_ctl;
            den_reg <= in_den;
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
            byp_reg <= in_byp;
        end
    end

    assign out_valid = v_reg;
    assign out_ctl   = ctl_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_sh    = sh_reg;
    assign out_byp   = byp_reg;

    `VPP_ASSERT_IMP(a_rem_below_den, v_reg && ctl_reg.apply && !ctl_reg.ovf[0], rem_reg[0] < den_reg, "remainder not below divisor")

endmodule
